// File: design/triac_half_cycle_power_control_assert.svh
// Assertion macros shared by the checker of the triac power control block.
// No dependencies; included by the checker file only.
`ifndef TRIAC_HALF_CYCLE_POWER_CONTROL_ASSERT_SVH
`define TRIAC_HALF_CYCLE_POWER_CONTROL_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define THPC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define THPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/thpc_pkg.sv
// Shared widths, codes and types of the triac half-cycle power control block.
// No dependencies; every other file of the block but the assertion header imports it.
package thpc_pkg;

    localparam int OPCODE_W = 2;
    localparam int SAMPLE_W = 10;
    localparam int POWER_W  = 7;
    localparam int WINDOW_W = 8;
    localparam int ERR_W    = 10;
    localparam int LEVEL_W  = 12;
    localparam int BAL_W    = 2;
    localparam int COUNT_W  = 16;
    localparam int SQ_W     = 2 * SAMPLE_W;
    localparam int SUM_W    = 36;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic signed [LEVEL_W-1:0] FIRE_THRESHOLD = 12'sd50;
    localparam logic signed [LEVEL_W-1:0] FULL_POWER     = 12'sd100;
    localparam logic signed [LEVEL_W-1:0] ERR_MAX        = 12'sd511;
    localparam logic signed [LEVEL_W-1:0] ERR_MIN        = -12'sd512;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 8'd50;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CROSSING  = 2'd0,
        OP_SAMPLE    = 2'd1,
        OP_PULSE_END = 2'd2,
        OP_RESTART   = 2'd3
    } t_opcode;

    typedef enum logic {
        REG_TARGET_POWER = 1'b0,
        REG_WINDOW       = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [POWER_W-1:0]  target_power;
        logic [WINDOW_W-1:0] window_half_cycles;
    } t_cfg;

    typedef struct packed {
        logic               triac_on;
        logic               fired;
        logic               window_open;
        logic [COUNT_W-1:0] sample_count;
        logic [SUM_W-1:0]   square_sum;
    } t_result;

endpackage

// File: design/thpc_item_if.sv
// Input channel of the triac power control block: valid/ready plus one event.
// Depends on thpc_pkg for the field widths.
interface thpc_item_if;
    import thpc_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [SAMPLE_W-1:0] adc_sample;

    modport source (output valid, output opcode, output adc_sample, input ready);
    modport sink   (input valid, input opcode, input adc_sample, output ready);
endinterface

// File: design/thpc_result_if.sv
// Result channel of the triac power control block: valid/ready plus status.
// Depends on thpc_pkg for the field widths.
interface thpc_result_if;
    import thpc_pkg::*;

    logic               valid;
    logic               ready;
    logic               triac_on;
    logic               fired;
    logic               window_open;
    logic [COUNT_W-1:0] sample_count;
    logic [SUM_W-1:0]   square_sum;

    modport source (output valid, output triac_on, output fired, output window_open,
                     output sample_count, output square_sum, input ready);
    modport sink   (input valid, input triac_on, input fired, input window_open,
                     input sample_count, input square_sum, output ready);
endinterface

// File: design/triac_half_cycle_power_control.sv
// Half-cycle triac power control with RMS sample accumulation. Every event
// (zero crossing, ADC sample, pulse end, restart request) gives one result
// transaction carrying the gate drive and the measurement totals after it.
// One event is taken per clock unless the output stalls. The event is registered
// in the input register, then the update logic writes its result into the result
// register, which drives the output. While a result waits on the output, one more event
// is taken into the input register and the input then stalls. The user must write
// configuration over APB only while no transaction is in flight; the block does not check.
module triac_half_cycle_power_control (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    thpc_item_if.sink                       i_item,
    thpc_result_if.source                   o_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [thpc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [thpc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [thpc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import thpc_pkg::*;

    t_cfg    cfg;
    t_result core_result;

    logic                r_in_valid;
    logic [OPCODE_W-1:0] r_in_opcode;
    logic [SAMPLE_W-1:0] r_in_sample;
    logic                r_out_valid;
    t_result             r_out;
    logic                advance;
    logic                step;

    thpc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign advance      = !r_out_valid || o_result.ready;
    assign step         = r_in_valid && advance;
    assign i_item.ready = !r_in_valid || advance;

    thpc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_opcode     (r_in_opcode),
        .i_adc_sample (r_in_sample),
        .i_cfg        (cfg),
        .o_result     (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
        if (i_item.valid && i_item.ready) begin
            r_in_opcode <= i_item.opcode;
            r_in_sample <= i_item.adc_sample;
        end
        if (step) begin
            r_out <= core_result;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.triac_on     = r_out.triac_on;
    assign o_result.fired        = r_out.fired;
    assign o_result.window_open  = r_out.window_open;
    assign o_result.sample_count = r_out.sample_count;
    assign o_result.square_sum   = r_out.square_sum;

endmodule

// File: design/thpc_apb_regs.sv
// APB configuration registers: target power and measurement window length.
// Depends on thpc_pkg.
module thpc_apb_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [thpc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [thpc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [thpc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output thpc_pkg::t_cfg                  o_cfg
);
    import thpc_pkg::*;

    logic [POWER_W-1:0]  r_target_power;
    logic [WINDOW_W-1:0] r_window;
    t_reg_idx            reg_idx;
    logic                wr_en;

    assign reg_idx = t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_power <= '0;
            r_window       <= WINDOW_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TARGET_POWER: r_target_power <= pwdata[POWER_W-1:0];
                REG_WINDOW:       r_window       <= pwdata[WINDOW_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TARGET_POWER: prdata = {{(APB_DATA_W-POWER_W){1'b0}}, r_target_power};
            REG_WINDOW:       prdata = {{(APB_DATA_W-WINDOW_W){1'b0}}, r_window};
        endcase
    end

    assign o_cfg.target_power       = r_target_power;
    assign o_cfg.window_half_cycles = r_window;

endmodule

// File: design/thpc_core.sv
// Control state of the block and its update logic for one event:
// error diffusion firing, DC balance, gate drive and RMS accumulation.
// Depends on thpc_pkg.
module thpc_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [thpc_pkg::OPCODE_W-1:0] i_opcode,
    input  logic [thpc_pkg::SAMPLE_W-1:0] i_adc_sample,
    input  thpc_pkg::t_cfg                i_cfg,
    output thpc_pkg::t_result             o_result
);
    import thpc_pkg::*;

    logic signed [ERR_W-1:0] r_error_acc, n_error_acc;
    logic signed [BAL_W-1:0] r_dc_balance, n_dc_balance;
    logic                    r_pol_neg, n_pol_neg;
    logic [WINDOW_W-1:0]     r_half_cycles, n_half_cycles;
    logic                    r_restart_pending, n_restart_pending;
    logic [COUNT_W-1:0]      r_count, n_count;
    logic [SUM_W-1:0]        r_sum, n_sum;
    logic                    r_gate, n_gate;

    logic signed [LEVEL_W-1:0] level;
    logic signed [LEVEL_W-1:0] err_pre;
    logic signed [BAL_W:0]     bal_sum;
    logic                      fire_raw;
    logic                      blocked;
    logic                      fire;
    logic                      win_open_now;
    logic [SQ_W-1:0]           square;
    logic [SUM_W:0]            sum_ext;
    t_opcode                   opcode;

    assign opcode = t_opcode'(i_opcode);

    assign level    = $signed({{(LEVEL_W-POWER_W){1'b0}}, i_cfg.target_power})
                    + {{(LEVEL_W-ERR_W){r_error_acc[ERR_W-1]}}, r_error_acc};
    assign fire_raw = level >= FIRE_THRESHOLD;
    // A positive firing is held off while the DC balance is 1, a negative one while it is negative.
    assign blocked  = r_pol_neg ? r_dc_balance[BAL_W-1] : (r_dc_balance == 2'sd1);
    assign fire     = fire_raw && !blocked;
    assign err_pre  = fire ? (level - FULL_POWER) : level;
    assign bal_sum  = {r_dc_balance[BAL_W-1], r_dc_balance} + (r_pol_neg ? -3'sd1 : 3'sd1);

    assign win_open_now = r_half_cycles < i_cfg.window_half_cycles;
    assign square       = i_adc_sample * i_adc_sample;
    assign sum_ext      = {1'b0, r_sum} + {{(SUM_W+1-SQ_W){1'b0}}, square};

    always_comb begin
        n_error_acc       = r_error_acc;
        n_dc_balance      = r_dc_balance;
        n_pol_neg         = r_pol_neg;
        n_half_cycles     = r_half_cycles;
        n_restart_pending = r_restart_pending;
        n_count           = r_count;
        n_sum             = r_sum;
        n_gate            = r_gate;

        unique case (opcode)
            OP_CROSSING: begin
                n_gate    = fire;
                n_pol_neg = !r_pol_neg;
                if (err_pre > ERR_MAX) begin
                    n_error_acc = ERR_MAX[ERR_W-1:0];
                end else if (err_pre < ERR_MIN) begin
                    n_error_acc = ERR_MIN[ERR_W-1:0];
                end else begin
                    n_error_acc = err_pre[ERR_W-1:0];
                end
                if (fire) begin
                    if (bal_sum > 3'sd1) begin
                        n_dc_balance = 2'sd1;
                    end else if (bal_sum < -3'sd2) begin
                        n_dc_balance = -2'sd2;
                    end else begin
                        n_dc_balance = bal_sum[BAL_W-1:0];
                    end
                end
                if (win_open_now) begin
                    n_half_cycles = r_half_cycles + 1'b1;
                end
                // A pending restart wins over the advance of the half-cycle counter.
                if (r_restart_pending) begin
                    n_restart_pending = 1'b0;
                    n_half_cycles     = '0;
                    n_count           = '0;
                    n_sum             = '0;
                end
            end
            OP_SAMPLE: begin
                if (win_open_now) begin
                    n_sum = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
                    if (r_count != {COUNT_W{1'b1}}) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            OP_PULSE_END: begin
                n_gate = 1'b0;
            end
            OP_RESTART: begin
                n_restart_pending = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_acc       <= '0;
            r_dc_balance      <= '0;
            r_pol_neg         <= 1'b0;
            r_half_cycles     <= '0;
            r_restart_pending <= 1'b0;
            r_count           <= '0;
            r_sum             <= '0;
            r_gate            <= 1'b0;
        end else if (i_step) begin
            r_error_acc       <= n_error_acc;
            r_dc_balance      <= n_dc_balance;
            r_pol_neg         <= n_pol_neg;
            r_half_cycles     <= n_half_cycles;
            r_restart_pending <= n_restart_pending;
            r_count           <= n_count;
            r_sum             <= n_sum;
            r_gate            <= n_gate;
        end
    end

    // The result reports the state as it stands after this event.
    assign o_result.triac_on     = n_gate;
    assign o_result.fired        = (opcode == OP_CROSSING) && fire;
    assign o_result.window_open  = n_half_cycles < i_cfg.window_half_cycles;
    assign o_result.sample_count = n_count;
    assign o_result.square_sum   = n_sum;

endmodule

// File: design/thpc_checker.sv
// Port-level checks of the triac power control block, bound to its top level.
// Depends on thpc_pkg and the assertion macro header.
`include "triac_half_cycle_power_control_assert.svh"

module thpc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_res_valid,
    input logic                         i_res_ready,
    input logic                         i_triac_on,
    input logic                         i_fired,
    input logic                         i_window_open,
    input logic [thpc_pkg::COUNT_W-1:0] i_sample_count,
    input logic [thpc_pkg::SUM_W-1:0]   i_square_sum
);
    import thpc_pkg::*;

    // A crossing that fires leaves the gate driven.
    `THPC_ASSERT_ALWAYS(a_fired_gate_on, i_clk, i_rst_n, !i_res_valid || !i_fired || i_triac_on, "fired result with gate off")

    // No samples since restart means nothing has been summed either.
    `THPC_ASSERT_ALWAYS(a_empty_sum_zero, i_clk, i_rst_n, !i_res_valid || (i_sample_count != '0) || (i_square_sum == '0), "square sum without samples")

    // A stalled result transaction keeps its whole payload.
    `THPC_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_triac_on) && $stable(i_fired) && $stable(i_window_open) && $stable(i_sample_count) && $stable(i_square_sum), "stalled result changed")

endmodule

bind triac_half_cycle_power_control thpc_checker u_thpc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_result.valid),
    .i_res_ready    (o_result.ready),
    .i_triac_on     (o_result.triac_on),
    .i_fired        (o_result.fired),
    .i_window_open  (o_result.window_open),
    .i_sample_count (o_result.sample_count),
    .i_square_sum   (o_result.square_sum)
);
